// ===== hdl/tst_pkg.sv =====
`default_nettype none

package tst_pkg;

  // Operation codes carried in the op field of an input word.
  typedef enum logic [2:0] {
    OP_LOOKUP    = 3'd0,
    OP_FIND      = 3'd1,
    OP_ACTIVE    = 3'd2,
    OP_COMMIT    = 3'd3,
    OP_ABORT     = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    SLOT_FREE      = 2'd0,
    SLOT_ACTIVE    = 2'd1,
    SLOT_COMMITTED = 2'd2,
    SLOT_ABORTED   = 2'd3
  } slot_st_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_EXEC,
    ST_SCAN,
    ST_FINISH
  } state_t;

  localparam int unsigned TXN_W   = 32;
  localparam int unsigned SCN_W   = 64;
  localparam int unsigned FOUND_W = 3;

  typedef struct packed {
    logic               has_status;
    logic [SCN_W-1:0]   slot_commit_scn;
    logic [TXN_W-1:0]   slot_txn;
    logic [FOUND_W-1:0] slot_found;
    logic               ok;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/transaction_slot_table.sv =====
// Transaction slot table.
//
// Commands enter on the s_axis channel, one word per command, and each
// command gives exactly one result word on the m_axis channel. A command
// is a lookup, a find, or a stamp (active, committed, aborted) against one
// of SLOT_COUNT slots. The single configuration bit, table_present, is
// written through cfg_wr_en / cfg_wr_data; the user must write it only while
// idle, as the block does not enforce it. With it low every command fails.
//
// A lookup or stamp word passes through issue with slot read, execute and
// result before it reaches the m_axis register, and the input is not ready
// again until the result is handed on, so no new command is taken before
// the last is through. A find walks the slots one per cycle through the
// shared id comparator and stops early when the owning slot is found.
//
// Reset clears the slot valid flags at once, so every slot reads as free,
// and sets table_present to one. A stalled result waits in the output
// register while the next command runs; that one then holds in its final
// state, with the input not ready, until the register drains.

`default_nettype none

module transaction_slot_table #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wr_en,
  input  wire logic         cfg_wr_data,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // op [2:0], slot_index [10:3], txn_id [42:11], scn_value [106:43], zero fill
  input  wire logic [111:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // ok [0], slot_found [3:1], slot_txn [35:4], slot_commit_scn [99:36],
  // has_status [100], zero fill
  output logic [103:0]      m_axis_tdata
);

  import tst_pkg::*;

  logic table_present;
  logic res_valid;
  logic res_ready;
  res_t res;
  res_t out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_present <= 1'b1;
    end else if (cfg_wr_en) begin
      table_present <= cfg_wr_data;
    end
  end

  tst_ctrl #(.SLOT_COUNT(SLOT_COUNT)) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .table_present (table_present),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_op         (s_axis_tdata[2:0]),
    .in_slot_index (s_axis_tdata[10:3]),
    .in_txn_id     (s_axis_tdata[42:11]),
    .in_scn_value  (s_axis_tdata[106:43]),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  // The output register frees as soon as its word is taken.
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_word <= res;
    end
  end

  assign m_axis_tdata = {3'b000, out_word};

endmodule

`default_nettype wire

// ===== hdl/tst_ram.sv =====
`default_nettype none

module tst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tst_ctrl.sv =====
`default_nettype none

module tst_ctrl #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 table_present,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [2:0]           in_op,
  input  wire logic [7:0]           in_slot_index,
  input  wire logic [31:0]          in_txn_id,
  input  wire logic [63:0]          in_scn_value,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output tst_pkg::res_t             res
);

  import tst_pkg::*;

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [8:0] SlotLimit = 9'(SLOT_COUNT);
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(SLOT_COUNT - 1);

  state_t state, state_next;

  logic [2:0]        op_r;
  logic [IDX_W-1:0]  idx_r;
  logic              in_range_r;
  logic [TXN_W-1:0]  txn_r;
  logic [SCN_W-1:0]  scn_r;
  logic [IDX_W-1:0]  rd_idx, rd_idx_next;
  logic              have_free, have_free_next;
  logic [IDX_W-1:0]  free_at, free_at_next;
  res_t              res_next;

  // One valid flag per slot; a slot never written reads as free.
  logic [SLOT_COUNT-1:0] valid_bits;
  logic                  valid_rd;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              st_we, txn_we, cmt_we;
  logic [1:0]        st_wdata;
  logic [SCN_W-1:0]  cmt_wdata;
  logic [1:0]        st_rd;
  logic [TXN_W-1:0]  txn_rd;
  logic [SCN_W-1:0]  cmt_rd;
  slot_st_t          eff_st;
  logic [7:0]        idx_wide;
  logic              txn_match;

  tst_ram #(.WIDTH(2), .DEPTH(SLOT_COUNT)) u_status_ram (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (idx_r),
    .wr_data (st_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (st_rd)
  );

  tst_ram #(.WIDTH(TXN_W), .DEPTH(SLOT_COUNT)) u_txn_ram (
    .clk     (clk),
    .wr_en   (txn_we),
    .wr_addr (idx_r),
    .wr_data (txn_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (txn_rd)
  );

  tst_ram #(.WIDTH(SCN_W), .DEPTH(SLOT_COUNT)) u_commit_ram (
    .clk     (clk),
    .wr_en   (cmt_we),
    .wr_addr (idx_r),
    .wr_data (cmt_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (cmt_rd)
  );

  assign eff_st    = valid_rd ? slot_st_t'(st_rd) : SLOT_FREE;
  assign idx_wide  = 8'(rd_idx);
  // The shared compare unit: one slot id against the requested id.
  assign txn_match = (txn_rd == txn_r);
  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_FINISH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      valid_bits <= '0;
    end else begin
      state <= state_next;
      if (st_we) begin
        valid_bits[idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r       <= in_op;
      idx_r      <= in_slot_index[IDX_W-1:0];
      in_range_r <= ({1'b0, in_slot_index} < SlotLimit);
      txn_r      <= in_txn_id;
      scn_r      <= in_scn_value;
    end
    if (rd_en) begin
      valid_rd <= valid_bits[rd_addr];
    end
    rd_idx    <= rd_idx_next;
    have_free <= have_free_next;
    free_at   <= free_at_next;
    res       <= res_next;
  end

  always_comb begin
    state_next     = state;
    rd_en          = 1'b0;
    rd_addr        = idx_r;
    rd_idx_next    = rd_idx;
    have_free_next = have_free;
    free_at_next   = free_at;
    res_next       = res;
    st_we          = 1'b0;
    txn_we         = 1'b0;
    cmt_we         = 1'b0;
    st_wdata       = SLOT_FREE;
    cmt_wdata      = '0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_ISSUE;
        end
      end

      ST_ISSUE: begin
        res_next       = '0;
        have_free_next = 1'b0;
        free_at_next   = '0;
        state_next     = ST_FINISH;
        if (table_present) begin
          case (op_r)
            OP_FIND: begin
              rd_en       = 1'b1;
              rd_addr     = '0;
              rd_idx_next = '0;
              state_next  = ST_SCAN;
            end
            OP_LOOKUP, OP_ACTIVE, OP_COMMIT, OP_ABORT: begin
              if (in_range_r) begin
                rd_en       = 1'b1;
                rd_idx_next = idx_r;
                state_next  = ST_EXEC;
              end
            end
            default: begin
              state_next = ST_FINISH;
            end
          endcase
        end
      end

      ST_EXEC: begin
        state_next = ST_FINISH;
        case (op_r)
          OP_LOOKUP: begin
            if (eff_st != SLOT_FREE) begin
              res_next.ok              = 1'b1;
              res_next.slot_txn        = txn_rd;
              res_next.slot_commit_scn = cmt_rd;
              res_next.has_status      = (eff_st == SLOT_COMMITTED) && (cmt_rd != '0);
            end
          end
          OP_ACTIVE: begin
            res_next.ok = 1'b1;
            st_we       = 1'b1;
            st_wdata    = SLOT_ACTIVE;
            txn_we      = 1'b1;
            cmt_we      = 1'b1;
            cmt_wdata   = '0;
          end
          OP_COMMIT: begin
            if (eff_st == SLOT_ACTIVE) begin
              res_next.ok = 1'b1;
              st_we       = 1'b1;
              st_wdata    = SLOT_COMMITTED;
              cmt_we      = 1'b1;
              cmt_wdata   = scn_r;
            end
          end
          OP_ABORT: begin
            if (eff_st == SLOT_ACTIVE) begin
              res_next.ok = 1'b1;
              st_we       = 1'b1;
              st_wdata    = SLOT_ABORTED;
              cmt_we      = 1'b1;
              cmt_wdata   = '0;
            end
          end
          default: begin
            res_next = '0;
          end
        endcase
      end

      ST_SCAN: begin
        // Data for slot rd_idx is on the read ports; fetch the next slot meanwhile.
        if (eff_st == SLOT_ACTIVE && txn_match) begin
          res_next.ok         = 1'b1;
          res_next.slot_found = idx_wide[FOUND_W-1:0];
          state_next          = ST_FINISH;
        end else if (rd_idx == LastIdx) begin
          if (have_free || eff_st == SLOT_FREE) begin
            res_next.ok         = 1'b1;
            res_next.slot_found = have_free ? FOUND_W'(8'(free_at)) : idx_wide[FOUND_W-1:0];
          end
          state_next = ST_FINISH;
        end else begin
          if (eff_st == SLOT_FREE && !have_free) begin
            have_free_next = 1'b1;
            free_at_next   = rd_idx;
          end
          rd_en       = 1'b1;
          rd_addr     = rd_idx + IDX_W'(1);
          rd_idx_next = rd_idx + IDX_W'(1);
        end
      end

      ST_FINISH: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
